// ===== src/target_centering_p_controller_assert.svh =====
// Assertion macros used by the target centering controller back end.
`ifndef TARGET_CENTERING_P_CONTROLLER_ASSERT_SVH
`define TARGET_CENTERING_P_CONTROLLER_ASSERT_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define TCPC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tcpc assertion failed");

// Implication checked in the next cycle, disabled while reset is asserted.
`define TCPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tcpc assertion failed");

`endif

// ===== src/tcpc_pkg.sv =====
`timescale 1ns / 1ps

package tcpc_pkg;

    // Confidence of exactly one in Q1.10.
    localparam logic [10:0] CONF_ONE = 11'd1024;

    // Depth of the frame record queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [2:0] CFG_TARGET_CLASS   = 3'd0;
    localparam logic [2:0] CFG_MIN_CONFIDENCE = 3'd1;
    localparam logic [2:0] CFG_GAIN           = 3'd2;
    localparam logic [2:0] CFG_TOLERANCE      = 3'd3;
    localparam logic [2:0] CFG_HOLD_COUNT     = 3'd4;
    localparam logic [2:0] CFG_COMMAND_LIMIT  = 3'd5;
    localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd6;

    // Register values after reset.
    localparam logic [7:0]  RST_TARGET_CLASS   = 8'd0;
    localparam logic [10:0] RST_MIN_CONFIDENCE = 11'd307;
    localparam logic [15:0] RST_GAIN           = 16'd1311;
    localparam logic [15:0] RST_TOLERANCE      = 16'd128;
    localparam logic [15:0] RST_HOLD_COUNT     = 16'd10;
    localparam logic [14:0] RST_COMMAND_LIMIT  = 15'd2560;
    localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd0;

    typedef enum logic [2:0] {
        ST_NO_WIDTH  = 3'd0,
        ST_NO_DET    = 3'd1,
        ST_NO_MATCH  = 3'd2,
        ST_TRACKING  = 3'd3,
        ST_SUCCESS   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  target_class;
        logic [10:0] min_confidence;
        logic [15:0] gain;
        logic [15:0] tolerance;
        logic [15:0] hold_count;
        logic [14:0] command_limit;
        logic [11:0] image_width;
    } cfg_t;

    typedef struct packed {
        logic        frame_empty;
        logic [7:0]  class_id;
        logic [10:0] confidence;
        logic [15:0] center_x;
        logic        last_in_frame;
    } det_in_t;

    typedef struct packed {
        status_t            status;
        logic               centred;
        logic [15:0]        best_center_x;
        logic [10:0]        top_confidence;
        logic signed [15:0] yaw_command;
    } result_t;

    // One finished frame as handed from the front end to the back end.
    typedef struct packed {
        logic        empty_marker;
        logic        have_best;
        logic [10:0] top_conf;
        logic [15:0] best_x;
    } frame_rec_t;

endpackage

// ===== src/target_centering_p_controller.sv =====
`timescale 1ns / 1ps

// Target centering yaw controller. One detection transaction is accepted per
// clock cycle on the s_ channel while the record queue has room; a frame ends
// at an item with last_in_frame or frame_empty set, and each frame end produces
// exactly one result transaction on the m_ channel once its record has passed
// through the record queue and the output register. The front end filters
// detections and tracks the most confident match of the frame; completed
// frames pass through a four-entry record queue to the back end, whose multiply
// and clamp stage gives one result per cycle while m_ready is high; input stalls
// once four records queue behind a stalled result. Configuration registers are
// written through cfg_wr_en, cfg_addr and cfg_wr_data; the user must write them
// only while no transaction is in flight, and the block does not enforce this.

module target_centering_p_controller
    import tcpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  det_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_data
);

    cfg_t       cfg_reg, cfg_next;
    logic       in_fire;
    logic       rec_push;
    frame_rec_t rec_push_data;
    logic       rec_pop;
    logic       q_full;
    logic       q_not_empty;
    frame_rec_t q_head;

    // Configuration register file.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TARGET_CLASS:   cfg_next.target_class   = cfg_wr_data[7:0];
                CFG_MIN_CONFIDENCE: cfg_next.min_confidence = cfg_wr_data[10:0];
                CFG_GAIN:           cfg_next.gain           = cfg_wr_data;
                CFG_TOLERANCE:      cfg_next.tolerance      = cfg_wr_data;
                CFG_HOLD_COUNT:     cfg_next.hold_count     = cfg_wr_data;
                CFG_COMMAND_LIMIT:  cfg_next.command_limit  = cfg_wr_data[14:0];
                CFG_IMAGE_WIDTH:    cfg_next.image_width    = cfg_wr_data[11:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_class   <= RST_TARGET_CLASS;
            cfg_reg.min_confidence <= RST_MIN_CONFIDENCE;
            cfg_reg.gain           <= RST_GAIN;
            cfg_reg.tolerance      <= RST_TOLERANCE;
            cfg_reg.hold_count     <= RST_HOLD_COUNT;
            cfg_reg.command_limit  <= RST_COMMAND_LIMIT;
            cfg_reg.image_width    <= RST_IMAGE_WIDTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input handshake: accept while the record queue has room.
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    tcpc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_fire  (in_fire),
        .in_det   (s_data),
        .rec_push (rec_push),
        .rec_data (rec_push_data)
    );

    tcpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (rec_push_data),
        .pop       (rec_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tcpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rec_valid (q_not_empty),
        .rec       (q_head),
        .rec_pop   (rec_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== src/tcpc_front.sv =====
`timescale 1ns / 1ps

module tcpc_front
    import tcpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  det_in_t    in_det,
    output logic       rec_push,
    output frame_rec_t rec_data
);

    logic        have_best_reg, have_best_next;
    logic [10:0] top_conf_reg, top_conf_next;
    logic [15:0] best_x_reg, best_x_next;
    logic [10:0] min_eff;
    logic        match;
    logic        take;
    logic        frame_end;

    // Filter the detection and decide whether it beats the running best.
    always_comb begin
        min_eff   = (cfg.min_confidence > CONF_ONE) ? CONF_ONE : cfg.min_confidence;
        match     = (in_det.class_id == cfg.target_class) && (in_det.confidence >= min_eff);
        take      = match && (!have_best_reg || (in_det.confidence > top_conf_reg));
        frame_end = in_det.frame_empty || in_det.last_in_frame;
    end

    // Frame record including the current detection.
    always_comb begin
        rec_push              = in_fire && frame_end;
        rec_data.empty_marker = in_det.frame_empty;
        rec_data.have_best    = have_best_reg || take;
        rec_data.top_conf     = take ? in_det.confidence : top_conf_reg;
        rec_data.best_x       = take ? in_det.center_x : best_x_reg;
    end

    // Running best: cleared at every frame end, updated otherwise.
    always_comb begin
        have_best_next = have_best_reg;
        top_conf_next  = top_conf_reg;
        best_x_next    = best_x_reg;
        if (in_fire) begin
            if (frame_end) begin
                have_best_next = 1'b0;
                top_conf_next  = '0;
                best_x_next    = '0;
            end else if (take) begin
                have_best_next = 1'b1;
                top_conf_next  = in_det.confidence;
                best_x_next    = in_det.center_x;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            top_conf_reg  <= '0;
            best_x_reg    <= '0;
        end else begin
            have_best_reg <= have_best_next;
            top_conf_reg  <= top_conf_next;
            best_x_reg    <= best_x_next;
        end
    end

endmodule

// ===== src/tcpc_queue.sv =====
`timescale 1ns / 1ps

module tcpc_queue
    import tcpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_rec_t push_data,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output frame_rec_t head
);

    frame_rec_t                 entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]       count_reg, count_next;

    // Status flags and head entry.
    always_comb begin
        full      = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
        not_empty = (count_reg != '0);
        head      = entries_reg[rd_ptr_reg];
    end

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/tcpc_back.sv =====
`timescale 1ns / 1ps

module tcpc_back
    import tcpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       rec_valid,
    input  frame_rec_t rec,
    output logic       rec_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_data
);

    `include "target_centering_p_controller_assert.svh"

    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic [15:0]        stable_reg, stable_next;
    logic signed [17:0] err;
    logic signed [17:0] neg_err;
    logic [16:0]        abs_err;
    logic signed [34:0] product;
    logic signed [22:0] cmd_full;
    logic signed [22:0] lim;
    logic signed [22:0] cmd_clamped;
    logic               centred;
    logic [15:0]        stable_inc;
    logic [15:0]        hold_eff;

    // Error from image centre, command and clamp.
    always_comb begin
        err      = $signed({2'b00, rec.best_x}) - $signed({3'b000, cfg.image_width, 3'b000});
        neg_err  = -err;
        abs_err  = err[17] ? 17'(neg_err) : 17'(err);
        product  = $signed({1'b0, cfg.gain}) * neg_err;
        cmd_full = 23'(product >>> 12);
        lim      = $signed({8'b0, cfg.command_limit});
        if (cmd_full > lim) begin
            cmd_clamped = lim;
        end else if (cmd_full < -lim) begin
            cmd_clamped = -lim;
        end else begin
            cmd_clamped = cmd_full;
        end
        centred    = ({1'b0, abs_err} <= {2'b00, cfg.tolerance});
        stable_inc = (stable_reg == 16'hFFFF) ? stable_reg : stable_reg + 16'd1;
        hold_eff   = (cfg.hold_count == '0) ? 16'd1 : cfg.hold_count;
    end

    // Take a frame record whenever the output register is free or draining.
    always_comb begin
        rec_pop        = rec_valid && (!out_valid_reg || m_ready);
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        stable_next    = stable_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (rec_pop) begin
            out_valid_next          = 1'b1;
            out_next.centred        = 1'b0;
            out_next.best_center_x  = '0;
            out_next.top_confidence = '0;
            out_next.yaw_command    = '0;
            stable_next             = '0;
            if (rec.empty_marker) begin
                out_next.status = (cfg.image_width == '0) ? ST_NO_WIDTH : ST_NO_DET;
            end else if (cfg.image_width == '0) begin
                out_next.status = ST_NO_WIDTH;
            end else if (!rec.have_best) begin
                out_next.status = ST_NO_MATCH;
            end else begin
                out_next.centred        = centred;
                out_next.best_center_x  = rec.best_x;
                out_next.top_confidence = rec.top_conf;
                if (centred && (stable_inc >= hold_eff)) begin
                    out_next.status = ST_SUCCESS;
                end else begin
                    out_next.status      = ST_TRACKING;
                    out_next.yaw_command = 16'(cmd_clamped);
                    stable_next          = centred ? stable_inc : '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            stable_reg    <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            stable_reg    <= stable_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A success result carries a zero command and a centred target.
    `TCPC_ASSERT_NOW(a_success_zero_cmd, aclk, aresetn,
        out_valid_reg && (out_reg.status == ST_SUCCESS),
        (out_reg.yaw_command == '0) && out_reg.centred)

    // Idle results carry no detection and no command.
    `TCPC_ASSERT_NOW(a_idle_zeroed, aclk, aresetn,
        out_valid_reg && ((out_reg.status == ST_NO_WIDTH) ||
        (out_reg.status == ST_NO_DET) || (out_reg.status == ST_NO_MATCH)),
        (out_reg.yaw_command == '0) && (out_reg.best_center_x == '0) && !out_reg.centred)

    // Any idle result clears the centred frame counter.
    `TCPC_ASSERT_NEXT(a_idle_clears_count, aclk, aresetn,
        rec_pop && (rec.empty_marker || !rec.have_best),
        stable_reg == '0)

endmodule
